// ----- sv/conference_mix_minus_mixer_top_defines.svh -----
// Assertion macros used by the mix-minus mixer checker.
`ifndef CONFERENCE_MIX_MINUS_MIXER_TOP_DEFINES_SVH
`define CONFERENCE_MIX_MINUS_MIXER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while reset is asserted.
`define CMM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked at a later clock edge set by dly.
`define CMM_ASSERT_DELAY(label, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

// ----- sv/cmm_pkg.sv -----
// Shared constants and register codes for the conference mix-minus mixer.
package cmm_pkg;

	// Number of conference stream lanes; each lane has its own sample port.
	localparam int LANES = 8;
	// Default sample width of the PCM streams.
	localparam int SAMPLE_BITS = 16;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = LANES;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_MASK = 1'b0,
		REG_STEREO_MODE = 1'b1
	} cfg_reg_t;

	// Pipeline depth from start to done.
	localparam int LATENCY = 3;

endpackage

// ----- sv/conference_mix_minus_mixer_top.sv -----
// Top level of the conference mix-minus mixer.
//
// The mixer takes one sample instant per clock: a transfer happens at every
// rising edge where start is high and busy is low, and busy is never raised,
// so a new instant may follow in every cycle. Results leave in order, one
// per transfer, each shown for exactly one cycle with done high. The
// receiver cannot hold results off, so it must take them in the cycle they
// appear. Each result passes through the pipeline registers in turn: an
// input register that zeroes inactive lanes, a register holding the sum
// over all lanes, and the result register after the per-lane subtract and
// clamp. In mono mode full_mix carries the clamped sum of all active lanes
// and minus_k the clamped sum without lane k, with left_out and right_out
// zero. In stereo mode lanes 0 and 1 pass to left_out and right_out (zero
// when their active bit is clear) and all mix outputs are zero.
// Configuration writes take effect at once and should be made only while
// no transfer is in flight.
module conference_mix_minus_mixer_top #(
	parameter int SAMPLE_BITS = cmm_pkg::SAMPLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	output logic                                done,
	input  logic                                cfg_wr_en,
	input  logic [cmm_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [cmm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic signed [SAMPLE_BITS-1:0]       sample_0,
	input  logic signed [SAMPLE_BITS-1:0]       sample_1,
	input  logic signed [SAMPLE_BITS-1:0]       sample_2,
	input  logic signed [SAMPLE_BITS-1:0]       sample_3,
	input  logic signed [SAMPLE_BITS-1:0]       sample_4,
	input  logic signed [SAMPLE_BITS-1:0]       sample_5,
	input  logic signed [SAMPLE_BITS-1:0]       sample_6,
	input  logic signed [SAMPLE_BITS-1:0]       sample_7,
	output logic signed [SAMPLE_BITS-1:0]       full_mix,
	output logic signed [SAMPLE_BITS-1:0]       minus_0,
	output logic signed [SAMPLE_BITS-1:0]       minus_1,
	output logic signed [SAMPLE_BITS-1:0]       minus_2,
	output logic signed [SAMPLE_BITS-1:0]       minus_3,
	output logic signed [SAMPLE_BITS-1:0]       minus_4,
	output logic signed [SAMPLE_BITS-1:0]       minus_5,
	output logic signed [SAMPLE_BITS-1:0]       minus_6,
	output logic signed [SAMPLE_BITS-1:0]       minus_7,
	output logic signed [SAMPLE_BITS-1:0]       left_out,
	output logic signed [SAMPLE_BITS-1:0]       right_out
);
	import cmm_pkg::*;

	// One guard bit beyond the full sum covers the sum minus one lane.
	localparam int SUM_W       = SAMPLE_BITS + $clog2(LANES) + 1;
	localparam int CLAMP_LIMIT = (1 << (SAMPLE_BITS - 1)) - 3;
	localparam logic signed [SUM_W-1:0] CLAMP_HI = SUM_W'(CLAMP_LIMIT);
	localparam logic signed [SUM_W-1:0] CLAMP_LO = SUM_W'(-CLAMP_LIMIT);

	typedef logic signed [SAMPLE_BITS-1:0] samp_t;
	typedef logic signed [SUM_W-1:0]       sum_t;

	// Configuration registers.
	logic [LANES-1:0] active_mask_q;
	logic             stereo_mode_q;

	// Pipeline registers.
	samp_t samp_in [LANES];
	samp_t samp_s1 [LANES];
	samp_t samp_s2 [LANES];
	logic  vld_s1;
	logic  vld_s2;
	logic  stereo_s1;
	logic  stereo_s2;
	sum_t  sum_comb;
	sum_t  sum_s2;

	// Result registers.
	logic  done_q;
	samp_t full_mix_q;
	samp_t minus_q [LANES];
	samp_t left_q;
	samp_t right_q;

	logic accept;

	function automatic samp_t clamp_mix(input sum_t v);
		sum_t r;
		if (v < CLAMP_LO) begin
			r = CLAMP_LO;
		end else if (v > CLAMP_HI) begin
			r = CLAMP_HI;
		end else begin
			r = v;
		end
		return r[SAMPLE_BITS-1:0];
	endfunction

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign samp_in[0] = sample_0;
	assign samp_in[1] = sample_1;
	assign samp_in[2] = sample_2;
	assign samp_in[3] = sample_3;
	assign samp_in[4] = sample_4;
	assign samp_in[5] = sample_5;
	assign samp_in[6] = sample_6;
	assign samp_in[7] = sample_7;

	// Register writes; an index outside the list leaves both registers alone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_mask_q <= '0;
			stereo_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_idx)
				REG_ACTIVE_MASK: active_mask_q <= cfg_wdata[LANES-1:0];
				REG_STEREO_MODE: stereo_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Control of the pipeline: one valid bit per stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	// Stage 1: capture the samples, with inactive lanes forced to silence.
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < LANES; k++) begin
				samp_s1[k] <= active_mask_q[k] ? samp_in[k] : '0;
			end
			stereo_s1 <= stereo_mode_q;
		end
	end

	// Sum of all lanes at full precision.
	always_comb begin
		sum_comb = '0;
		for (int k = 0; k < LANES; k++) begin
			sum_comb = sum_comb + SUM_W'(samp_s1[k]);
		end
	end

	// Stage 2: hold the sum next to the lane samples it was built from.
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			sum_s2    <= sum_comb;
			samp_s2   <= samp_s1;
			stereo_s2 <= stereo_s1;
		end
	end

	// Stage 3: subtract each lane's own sample, clamp, and route by mode.
	always_ff @(posedge clk) begin
		if (vld_s2) begin
			if (stereo_s2) begin
				full_mix_q <= '0;
				for (int k = 0; k < LANES; k++) begin
					minus_q[k] <= '0;
				end
				left_q  <= samp_s2[0];
				right_q <= samp_s2[1];
			end else begin
				full_mix_q <= clamp_mix(sum_s2);
				for (int k = 0; k < LANES; k++) begin
					minus_q[k] <= clamp_mix(sum_s2 - SUM_W'(samp_s2[k]));
				end
				left_q  <= '0;
				right_q <= '0;
			end
		end
	end

	assign done      = done_q;
	assign full_mix  = full_mix_q;
	assign minus_0   = minus_q[0];
	assign minus_1   = minus_q[1];
	assign minus_2   = minus_q[2];
	assign minus_3   = minus_q[3];
	assign minus_4   = minus_q[4];
	assign minus_5   = minus_q[5];
	assign minus_6   = minus_q[6];
	assign minus_7   = minus_q[7];
	assign left_out  = left_q;
	assign right_out = right_q;

endmodule

// ----- sv/cmm_checker.sv -----
// Port-level assertion checker for the mix-minus mixer and its bind.
`include "conference_mix_minus_mixer_top_defines.svh"

module cmm_checker #(
	parameter int SAMPLE_BITS = cmm_pkg::SAMPLE_BITS
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic signed [SAMPLE_BITS-1:0] full_mix,
	input logic signed [SAMPLE_BITS-1:0] left_out,
	input logic signed [SAMPLE_BITS-1:0] right_out
);
	import cmm_pkg::*;

	localparam int CLAMP_LIMIT = (1 << (SAMPLE_BITS - 1)) - 3;
	localparam logic signed [SAMPLE_BITS-1:0] CLAMP_HI = SAMPLE_BITS'(CLAMP_LIMIT);
	localparam logic signed [SAMPLE_BITS-1:0] CLAMP_LO = SAMPLE_BITS'(-CLAMP_LIMIT);

	// Every transfer is followed by its result with done high.
	`CMM_ASSERT_DELAY(a_result_follows, start && !busy, 3, done, "result missing after transfer")

	// No result appears without a transfer that fed it.
	`CMM_ASSERT_SAME(a_no_spurious, done && $past(arst_n, LATENCY),
		$past(start && !busy, LATENCY), "result without a matching transfer")

	// The full mix stays inside the clamp limits whenever done is high.
	`CMM_ASSERT_SAME(a_mix_range, done, full_mix >= CLAMP_LO && full_mix <= CLAMP_HI,
		"full mix outside clamp limits")

	// Stereo routing and mono mixing never show at the same time.
	`CMM_ASSERT_SAME(a_mode_excl, done && (left_out != '0 || right_out != '0),
		full_mix == '0, "stereo and mono outputs both active")

endmodule

bind conference_mix_minus_mixer_top cmm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_cmm_checker (.*);

// ----- tb/sv/conference_mix_minus_mixer_top_test.sv -----
// Self-checking testbench for the conference mix-minus mixer top level.
module conference_mix_minus_mixer_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cmm_pkg::*;

	// The mix outputs saturate two codes short of the largest sample and three short of the smallest.
	localparam int MIX_LIMIT  = (1 << (SAMPLE_BITS - 1)) - 3;
	localparam int SAMPLE_MAX = (1 << (SAMPLE_BITS - 1)) - 1;
	localparam int SAMPLE_MIN = -SAMPLE_MAX - 1;
	// The run is stopped here whatever happens.
	localparam int RUN_LIMIT_NS = 5_000_000;
	// Mismatch lines beyond this count are counted but not printed.
	localparam int PRINT_CAP = 40;

	// One sample instant: a sample for every lane, lane 0 in the low slot.
	typedef logic [LANES-1:0][SAMPLE_BITS-1:0] lane_samples_t;

	// Everything the mixer shows in one result cycle.
	typedef struct packed {
		logic [SAMPLE_BITS-1:0]            full;
		logic [LANES-1:0][SAMPLE_BITS-1:0] minus;
		logic [SAMPLE_BITS-1:0]            left;
		logic [SAMPLE_BITS-1:0]            right;
	} mix_frame_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic signed [SAMPLE_BITS-1:0] sample_0, sample_1, sample_2, sample_3;
	logic signed [SAMPLE_BITS-1:0] sample_4, sample_5, sample_6, sample_7;
	logic signed [SAMPLE_BITS-1:0] full_mix, left_out, right_out;
	logic signed [SAMPLE_BITS-1:0] minus_0, minus_1, minus_2, minus_3;
	logic signed [SAMPLE_BITS-1:0] minus_4, minus_5, minus_6, minus_7;
	logic [LANES-1:0][SAMPLE_BITS-1:0] minus_bus;

	// Our own copy of the two configuration registers, updated on every write.
	logic [LANES-1:0] mask_model;
	logic stereo_model;

	// Mix frames still owed by the mixer, oldest first.
	mix_frame_t pending_mix[$];
	int error_count = 0;
	int results_seen = 0;
	// When set, the sender never pauses between transfers.
	bit burst_mode = 1'b0;

	assign minus_bus = {minus_7, minus_6, minus_5, minus_4,
		minus_3, minus_2, minus_1, minus_0};

	conference_mix_minus_mixer_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.done      (done),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.sample_0  (sample_0),
		.sample_1  (sample_1),
		.sample_2  (sample_2),
		.sample_3  (sample_3),
		.sample_4  (sample_4),
		.sample_5  (sample_5),
		.sample_6  (sample_6),
		.sample_7  (sample_7),
		.full_mix  (full_mix),
		.minus_0   (minus_0),
		.minus_1   (minus_1),
		.minus_2   (minus_2),
		.minus_3   (minus_3),
		.minus_4   (minus_4),
		.minus_5   (minus_5),
		.minus_6   (minus_6),
		.minus_7   (minus_7),
		.left_out  (left_out),
		.right_out (right_out)
	);

	// 10 ns clock: five high, five low.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Saturates a full-precision sum to the mix range and narrows it to a sample.
	function automatic logic [SAMPLE_BITS-1:0] clamp_to_mix(input int level);
		if (level > MIX_LIMIT)
			level = MIX_LIMIT;
		else if (level < -MIX_LIMIT)
			level = -MIX_LIMIT;
		return SAMPLE_BITS'(level);
	endfunction

	// Works out the frame the mixer should produce for one sample instant under
	// the given lane mask and routing mode. The sum is kept in a 32-bit int, so
	// eight full-scale lanes cannot wrap before the clamp.
	function automatic mix_frame_t predict_mix(input lane_samples_t lanes,
			input logic [LANES-1:0] mask, input logic stereo);
		int heard[LANES];
		int total;
		int k;
		mix_frame_t frame;
		total = 0;
		for (k = 0; k < LANES; k++) begin
			// A lane that is not attached is heard as silence.
			heard[k] = mask[k] ? int'($signed(lanes[k])) : 0;
			total += heard[k];
		end
		frame = '0;
		if (stereo) begin
			// Plain routing of lanes 0 and 1, no saturation and no mixing.
			frame.left  = SAMPLE_BITS'(heard[0]);
			frame.right = SAMPLE_BITS'(heard[1]);
		end else begin
			frame.full = clamp_to_mix(total);
			for (k = 0; k < LANES; k++)
				frame.minus[k] = clamp_to_mix(total - heard[k]);
		end
		return frame;
	endfunction

	// Every lane set to the same value.
	function automatic lane_samples_t all_lanes(input int value);
		lane_samples_t lanes;
		int k;
		for (k = 0; k < LANES; k++)
			lanes[k] = SAMPLE_BITS'(value);
		return lanes;
	endfunction

	// Draws one random sample. A bias of 1 or 2 pushes three draws in ten to
	// large positive or negative magnitudes, so that the sums run into the clamps.
	function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int bias);
		case ($urandom_range(0, 9))
			0: return SAMPLE_BITS'(SAMPLE_MIN);
			1: return SAMPLE_BITS'(SAMPLE_MAX);
			2: return '0;
			3: return '1;
			4, 5, 6: begin
				if (bias == 1)
					return SAMPLE_BITS'(int'($urandom_range(12000, SAMPLE_MAX)));
				else if (bias == 2)
					return SAMPLE_BITS'(-int'($urandom_range(12000, -SAMPLE_MIN)));
				else
					return SAMPLE_BITS'(int'($urandom_range(0, 400)) - 200);
			end
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	// Prints one mismatch line (up to a cap) and counts it.
	task automatic report_error(input string msg);
		if (error_count < PRINT_CAP)
			$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Writes one configuration register. Called at a falling edge while the
	// mixer is idle; returns at a falling edge with the write enable low again,
	// so back-to-back writes never lower and raise it in the same step.
	task automatic write_reg(input cfg_reg_t reg_id, input logic [CFG_DATA_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_idx   <= reg_id;
		cfg_wdata <= value;
		case (reg_id)
			REG_ACTIVE_MASK: mask_model = value[LANES-1:0];
			REG_STEREO_MODE: stereo_model = value[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Presents one sample instant and holds it until the transfer happens at a
	// rising edge with busy low. The expected frame is queued at the following
	// falling edge, well before any result for it can appear. Afterwards the
	// sender may pause for a random gap with start low.
	task automatic send_instant(input lane_samples_t lanes);
		int gap;
		start    <= 1'b1;
		sample_0 <= lanes[0];
		sample_1 <= lanes[1];
		sample_2 <= lanes[2];
		sample_3 <= lanes[3];
		sample_4 <= lanes[4];
		sample_5 <= lanes[5];
		sample_6 <= lanes[6];
		sample_7 <= lanes[7];
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
		pending_mix.push_back(predict_mix(lanes, mask_model, stereo_model));
		gap = burst_mode ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Drops start and waits until every queued frame has come back, plus the
	// pipeline depth, so that a register write cannot touch a transfer in flight.
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_mix.size() != 0)
			@(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	// Right after reset both registers are zero: no lane is attached and the
	// mixer is in mono mode, so every output must be silent whatever comes in.
	task automatic test_reset_state();
		lane_samples_t lanes;
		send_instant(all_lanes(SAMPLE_MAX));
		lanes = all_lanes(SAMPLE_MIN);
		lanes[1] = SAMPLE_BITS'(1234);
		send_instant(lanes);
	endtask

	// All eight lanes attached, mono mode: full-scale sums, the exact clamp
	// boundaries on both sides, and participants at opposite extremes.
	task automatic test_full_conference();
		lane_samples_t lanes;
		int k;
		wait_idle();
		write_reg(REG_ACTIVE_MASK, 8'hFF);
		write_reg(REG_STEREO_MODE, 8'h00);
		send_instant(all_lanes(SAMPLE_MAX));
		send_instant(all_lanes(SAMPLE_MIN));
		send_instant(all_lanes(0));
		// Alternating extremes: even lanes' minus mixes saturate low, odd ones sit just inside the top.
		for (k = 0; k < LANES; k++)
			lanes[k] = SAMPLE_BITS'((k % 2) ? SAMPLE_MIN : SAMPLE_MAX);
		send_instant(lanes);
		// One talker right at and just past each clamp boundary.
		lanes = all_lanes(0);
		lanes[0] = SAMPLE_BITS'(MIX_LIMIT);
		send_instant(lanes);
		lanes[0] = SAMPLE_BITS'(MIX_LIMIT + 1);
		send_instant(lanes);
		lanes[0] = SAMPLE_BITS'(-MIX_LIMIT);
		send_instant(lanes);
		lanes[0] = SAMPLE_BITS'(-MIX_LIMIT - 1);
		send_instant(lanes);
		// Sum of -1 from the two extremes; the others mix to small values.
		lanes[0] = SAMPLE_BITS'(SAMPLE_MIN);
		lanes[1] = SAMPLE_BITS'(SAMPLE_MAX);
		lanes[5] = SAMPLE_BITS'(-7);
		send_instant(lanes);
	endtask

	// Lanes whose bit is clear must be heard as silence, so their minus mix
	// equals the full mix. A single participant hears nothing of itself.
	task automatic test_inactive_lanes();
		lane_samples_t lanes;
		int k;
		wait_idle();
		write_reg(REG_ACTIVE_MASK, 8'b1010_0101);
		for (k = 0; k < LANES; k++)
			lanes[k] = SAMPLE_BITS'(9000 + 1000 * k);
		send_instant(lanes);
		send_instant(all_lanes(SAMPLE_MIN));
		wait_idle();
		write_reg(REG_ACTIVE_MASK, 8'h01);
		lanes[0] = SAMPLE_BITS'(-4321);
		send_instant(lanes);
	endtask

	// Stereo mode routes lanes 0 and 1 straight through, unclamped, and zeroes
	// the mix outputs; a lane without its active bit routes as silence.
	task automatic test_stereo_routing();
		lane_samples_t lanes;
		wait_idle();
		write_reg(REG_ACTIVE_MASK, 8'hFF);
		write_reg(REG_STEREO_MODE, 8'h01);
		lanes = all_lanes(20000);
		lanes[0] = SAMPLE_BITS'(SAMPLE_MIN);
		lanes[1] = SAMPLE_BITS'(SAMPLE_MAX);
		send_instant(lanes);
		lanes[0] = SAMPLE_BITS'(SAMPLE_MAX);
		lanes[1] = SAMPLE_BITS'(SAMPLE_MIN);
		send_instant(lanes);
		wait_idle();
		write_reg(REG_ACTIVE_MASK, 8'h02);
		send_instant(lanes);
		wait_idle();
		write_reg(REG_ACTIVE_MASK, 8'h01);
		send_instant(lanes);
	endtask

	// The stereo register keeps only its low bit of the write data.
	task automatic test_register_truncation();
		lane_samples_t lanes;
		wait_idle();
		write_reg(REG_ACTIVE_MASK, 8'hFF);
		write_reg(REG_STEREO_MODE, 8'hFE);
		lanes = all_lanes(-3000);
		lanes[1] = SAMPLE_BITS'(5555);
		send_instant(lanes);
		wait_idle();
		write_reg(REG_STEREO_MODE, 8'hFF);
		send_instant(lanes);
	endtask

	// Random phases, each with its own mask, routing mode, sample bias and
	// pacing. The first phases pin the extreme settings; later ones draw them.
	task automatic test_random_mix();
		lane_samples_t lanes;
		logic [LANES-1:0] mask;
		logic stereo;
		int phase;
		int n;
		int k;
		int bias;
		for (phase = 0; phase < 36; phase++) begin
			case (phase)
				0: begin mask = 8'hFF; stereo = 1'b0; end
				1: begin mask = 8'h00; stereo = 1'b0; end
				2: begin mask = 8'hFF; stereo = 1'b1; end
				3: begin mask = 8'h00; stereo = 1'b1; end
				default: begin
					case ($urandom_range(0, 5))
						0: mask = 8'hFF;
						1: mask = 8'h00;
						default: mask = LANES'($urandom());
					endcase
					stereo = ($urandom_range(0, 3) == 0);
				end
			endcase
			wait_idle();
			// Random upper bits on the stereo write exercise every data bit.
			if ($urandom_range(0, 1)) begin
				write_reg(REG_ACTIVE_MASK, mask);
				write_reg(REG_STEREO_MODE, {7'($urandom()), stereo});
			end else begin
				write_reg(REG_STEREO_MODE, {7'($urandom()), stereo});
				write_reg(REG_ACTIVE_MASK, mask);
			end
			burst_mode = ($urandom_range(0, 3) == 0);
			bias = $urandom_range(0, 2);
			for (n = 0; n < 51; n++) begin
				for (k = 0; k < LANES; k++)
					lanes[k] = pick_sample(bias);
				send_instant(lanes);
			end
		end
		burst_mode = 1'b0;
	endtask

	// Result checker: every cycle with done high carries one frame, and it is
	// compared field by field with the oldest frame still owed.
	always @(posedge clk) begin : check_results
		mix_frame_t want;
		int k;
		if (arst_n && done) begin
			if (pending_mix.size() == 0) begin
				report_error($sformatf("result with no transfer outstanding, full_mix %0d",
					full_mix));
			end else begin
				want = pending_mix.pop_front();
				if (full_mix !== want.full)
					report_error($sformatf("result %0d full_mix got %0d want %0d",
						results_seen, full_mix, $signed(want.full)));
				for (k = 0; k < LANES; k++)
					if (minus_bus[k] !== want.minus[k])
						report_error($sformatf("result %0d minus_%0d got %0d want %0d",
							results_seen, k, $signed(minus_bus[k]),
							$signed(want.minus[k])));
				if (left_out !== want.left)
					report_error($sformatf("result %0d left_out got %0d want %0d",
						results_seen, left_out, $signed(want.left)));
				if (right_out !== want.right)
					report_error($sformatf("result %0d right_out got %0d want %0d",
						results_seen, right_out, $signed(want.right)));
			end
			results_seen++;
		end
	end

	// Main sequence: reset once, then the directed tests, then the random
	// phases, then drain and report.
	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_idx      = REG_ACTIVE_MASK;
		cfg_wdata    = '0;
		sample_0     = '0;
		sample_1     = '0;
		sample_2     = '0;
		sample_3     = '0;
		sample_4     = '0;
		sample_5     = '0;
		sample_6     = '0;
		sample_7     = '0;
		mask_model   = '0;
		stereo_model = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		test_full_conference();
		test_inactive_lanes();
		test_stereo_routing();
		test_register_truncation();
		test_random_mix();

		// Let the last frames come back and give a stray late result a chance
		// to show up before the verdict.
		wait_idle();
		repeat (LATENCY + 2) @(negedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		#(RUN_LIMIT_NS);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
